### rtl/rscfp_pkg.sv
// ----------------------------------------------------------------------------
// rscfp_pkg
// Shared constants, types and hex decode for the card frame parser.
// ----------------------------------------------------------------------------
package rscfp_pkg;

    localparam int FRAME_BYTES = 14;
    localparam int RAW_BYTES   = 4;
    localparam int CNT_W       = 4;
    localparam int ID_W        = 32;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;

    localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] RAW_CNT   = CNT_W'(RAW_BYTES);
    localparam logic [CNT_W-1:0] RAW_TAIL  = CNT_W'(RAW_BYTES - 1);
    localparam logic [CNT_W-1:0] RAW_TWO   = CNT_W'(2 * RAW_BYTES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_RAW   = 5'b01000,
        S_FRAME = 5'b10000
    } state_t;

    typedef struct packed {
        logic append;
        logic start;
        logic drop;
        logic shift1;
        logic close_frame;
        logic frame_out;
        logic raw_out;
    } dp_cmd_t;

    typedef struct packed {
        logic             in_frame;
        logic             locked;
        logic [CNT_W-1:0] count;
        logic             rx_start;
        logic             frame_ok;
        logic             start_found;
        logic             head_start;
        logic             out_free;
        logic             raw_final;
    } dp_status_t;

    // bit 4 set for a valid hex character, bits 3:0 the nibble
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res = {1'b1, 4'(ch - 8'h30)};
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            res = {1'b1, 4'(ch - 8'h37)};
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            res = {1'b1, 4'(ch - 8'h57)};
        end
        return res;
    endfunction

endpackage

### rtl/rscfp_in_if.sv
// ----------------------------------------------------------------------------
// rscfp_in_if
// Valid/ready channel carrying one received reader byte per request.
// ----------------------------------------------------------------------------
interface rscfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/rscfp_out_if.sv
// ----------------------------------------------------------------------------
// rscfp_out_if
// Valid/ready channel carrying one card ID result per request.
// ----------------------------------------------------------------------------
interface rscfp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] card_id;
    logic        from_raw;
    logic        last;

    modport source (output valid, output card_id, output from_raw, output last,
                    input ready);
    modport sink   (input valid, input card_id, input from_raw, input last,
                    output ready);
endinterface

### rtl/rscfp_dp.sv
// ----------------------------------------------------------------------------
// rscfp_dp
// Held byte line, frame check, count and mode flags, result register.
// ----------------------------------------------------------------------------
module rscfp_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rscfp_pkg::dp_cmd_t                  cmd,
    input  logic [7:0]                          rx_byte,
    input  logic                                out_ready,
    output rscfp_pkg::dp_status_t               st,
    output logic                                out_valid,
    output logic [rscfp_pkg::ID_W-1:0]          card_id,
    output logic                                from_raw,
    output logic                                last
);

    localparam int FB = rscfp_pkg::FRAME_BYTES;
    localparam int RB = rscfp_pkg::RAW_BYTES;
    localparam int CW = rscfp_pkg::CNT_W;

    logic [7:0]    held_reg [FB];
    logic [CW-1:0] count_reg, count_next;
    logic          in_frame_reg, in_frame_next;
    logic          locked_reg, locked_next;
    logic          out_valid_reg;
    logic [31:0]   card_id_reg;
    logic          from_raw_reg;
    logic          last_reg;

    logic [CW-1:0] append_idx;
    logic [4:0]    nib [12];
    logic [7:0]    part [6];
    logic          hex_ok;
    logic [7:0]    xsum;
    logic [31:0]   frame_id;
    logic [31:0]   raw_id;
    logic          found;

    always_comb
    begin
        hex_ok = 1'b1;
        xsum   = 8'd0;
        for (int k = 0; k < 12; k++)
        begin
            nib[k] = rscfp_pkg::hex_nibble(held_reg[k + 1]);
            hex_ok = hex_ok & nib[k][4];
        end
        for (int k = 0; k < 6; k++)
        begin
            part[k] = {nib[2 * k][3:0], nib[2 * k + 1][3:0]};
        end
        for (int k = 0; k < 5; k++)
        begin
            xsum = xsum ^ part[k];
        end
        frame_id = {part[1], part[2], part[3], part[4]};
        raw_id   = {held_reg[0], held_reg[1], held_reg[2], held_reg[3]};
        found    = 1'b0;
        for (int k = 1; k < FB; k++)
        begin
            found = found | (held_reg[k] == rscfp_pkg::START_BYTE);
        end
    end

    assign append_idx = (!in_frame_reg && count_reg >= rscfp_pkg::RAW_CNT) ? '0 : count_reg;

    always_comb
    begin
        st.in_frame    = in_frame_reg;
        st.locked      = locked_reg;
        st.count       = count_reg;
        st.rx_start    = (rx_byte == rscfp_pkg::START_BYTE);
        st.frame_ok    = (held_reg[0] == rscfp_pkg::START_BYTE) &&
                         (held_reg[FB - 1] == rscfp_pkg::END_BYTE) &&
                         hex_ok && (xsum == part[5]) && (frame_id != 32'd0);
        st.start_found = found;
        st.head_start  = (held_reg[0] == rscfp_pkg::START_BYTE);
        st.out_free    = !out_valid_reg || out_ready;
        st.raw_final   = (count_reg < rscfp_pkg::RAW_TWO);
    end

    always_comb
    begin
        count_next    = count_reg;
        in_frame_next = in_frame_reg;
        locked_next   = locked_reg;
        if (cmd.frame_out || cmd.drop)
        begin
            count_next = '0;
        end
        else if (cmd.start)
        begin
            count_next = CW'(1);
        end
        else if (cmd.append)
        begin
            count_next = append_idx + CW'(1);
        end
        else if (cmd.shift1)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (cmd.raw_out)
        begin
            count_next = count_reg - rscfp_pkg::RAW_CNT;
        end
        if (cmd.start)
        begin
            in_frame_next = 1'b1;
        end
        else if (cmd.close_frame || cmd.frame_out)
        begin
            in_frame_next = 1'b0;
        end
        if (cmd.frame_out)
        begin
            locked_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            in_frame_reg  <= 1'b0;
            locked_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            in_frame_reg <= in_frame_next;
            locked_reg   <= locked_next;
            if (cmd.frame_out || cmd.raw_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            held_reg[0] <= rx_byte;
        end
        else if (cmd.append)
        begin
            for (int i = 0; i < FB; i++)
            begin
                if (CW'(i) == append_idx)
                begin
                    held_reg[i] <= rx_byte;
                end
            end
        end
        else if (cmd.shift1)
        begin
            for (int i = 0; i < FB - 1; i++)
            begin
                held_reg[i] <= held_reg[i + 1];
            end
        end
        else if (cmd.raw_out)
        begin
            for (int i = 0; i < FB - RB; i++)
            begin
                held_reg[i] <= held_reg[i + RB];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_out)
        begin
            card_id_reg  <= frame_id;
            from_raw_reg <= 1'b0;
            last_reg     <= 1'b1;
        end
        else if (cmd.raw_out)
        begin
            card_id_reg  <= raw_id;
            from_raw_reg <= 1'b1;
            last_reg     <= st.raw_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign card_id   = card_id_reg;
    assign from_raw  = from_raw_reg;
    assign last      = last_reg;

endmodule

### rtl/rscfp_ctrl.sv
// ----------------------------------------------------------------------------
// rscfp_ctrl
// Sequencer: byte intake, frame check, resync scan and result emission.
// ----------------------------------------------------------------------------
module rscfp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rscfp_pkg::dp_status_t st,
    output logic                  in_ready,
    output rscfp_pkg::dp_cmd_t    cmd
);

    rscfp_pkg::state_t state_reg, state_next;
    logic              accept;

    assign in_ready = (state_reg == rscfp_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            rscfp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (st.in_frame)
                    begin
                        cmd.append = 1'b1;
                        if (st.count == rscfp_pkg::LAST_CNT)
                        begin
                            state_next = rscfp_pkg::S_CHECK;
                        end
                    end
                    else if (st.rx_start)
                    begin
                        cmd.start = 1'b1;
                    end
                    else if (st.locked)
                    begin
                        cmd.drop = 1'b1;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        if (st.count == rscfp_pkg::RAW_TAIL)
                        begin
                            state_next = rscfp_pkg::S_RAW;
                        end
                    end
                end
            end
            rscfp_pkg::S_CHECK:
            begin
                if (st.frame_ok)
                begin
                    state_next = rscfp_pkg::S_FRAME;
                end
                else if (st.start_found)
                begin
                    cmd.shift1 = 1'b1;
                    state_next = rscfp_pkg::S_SCAN;
                end
                else
                begin
                    cmd.close_frame = 1'b1;
                    if (st.locked)
                    begin
                        cmd.drop   = 1'b1;
                        state_next = rscfp_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = rscfp_pkg::S_RAW;
                    end
                end
            end
            rscfp_pkg::S_SCAN:
            begin
                // advance until the next start byte reaches the head
                if (st.head_start)
                begin
                    state_next = rscfp_pkg::S_IDLE;
                end
                else
                begin
                    cmd.shift1 = 1'b1;
                end
            end
            rscfp_pkg::S_RAW:
            begin
                if (st.out_free)
                begin
                    cmd.raw_out = 1'b1;
                    if (st.raw_final)
                    begin
                        state_next = rscfp_pkg::S_IDLE;
                    end
                end
            end
            rscfp_pkg::S_FRAME:
            begin
                if (st.out_free)
                begin
                    cmd.frame_out = 1'b1;
                    state_next    = rscfp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rscfp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rscfp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/rfid_serial_card_frame_parser_top.sv
// Result path: a raw ID is loaded into the result register from S_RAW once its fourth byte
//   is held; a frame ID passes S_CHECK after the end byte, then S_FRAME loads it (check, then load).
// Intake: one byte per cycle while the sequencer is in S_IDLE; the fourth byte of a raw group, the byte
//   that closes a frame (valid, or bad and locked) and the one-byte-a-cycle resync shift hold intake
//   until done, as does a bad unlocked frame's three raw IDs; a stalled result register adds its wait.
// Reset (rst_n, async low) clears count, frame and lock flags and the result valid.
// ----------------------------------------------------------------------------
// rfid_serial_card_frame_parser_top
// Parses framed ASCII hex or raw four-byte card IDs from a reader byte stream.
// ----------------------------------------------------------------------------
module rfid_serial_card_frame_parser_top
(
    input  logic      clk,
    input  logic      rst_n,
    rscfp_in_if.sink  byte_ch,
    rscfp_out_if.source id_ch
);

    rscfp_pkg::dp_cmd_t    cmd;
    rscfp_pkg::dp_status_t st;

    rscfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .st       (st),
        .in_ready (byte_ch.ready),
        .cmd      (cmd)
    );

    rscfp_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rx_byte   (byte_ch.rx_byte),
        .out_ready (id_ch.ready),
        .st        (st),
        .out_valid (id_ch.valid),
        .card_id   (id_ch.card_id),
        .from_raw  (id_ch.from_raw),
        .last      (id_ch.last)
    );

`ifndef SYNTH
    a_frame_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        id_ch.valid && !id_ch.from_raw |-> id_ch.last)
        else $error("frame result without last");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st.count <= rscfp_pkg::FRAME_CNT)
        else $error("held count beyond frame length");

    a_lock_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(st.locked) |-> st.locked)
        else $error("framed lock released");
`endif

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the card frame parser. A byte-level model tracks
// held bytes, frame and lock state and queues the card IDs each request
// should produce. Stimulus runs in order: directed raw and bad-frame cases,
// random unlocked traffic, framed traffic after lock, then back-to-back good
// frames. Both channels see random stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 32;

    typedef struct packed {
        logic [31:0] card_id;
        logic        from_raw;
        logic        last;
    } card_result_t;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_END,
        FRAME_BAD_HEX,
        FRAME_ZERO_ID,
        FRAME_INNER_START
    } frame_kind_t;

    typedef logic [7:0] frame_t [rscfp_pkg::FRAME_BYTES];

    logic clk;
    logic rst_n;

    rscfp_in_if  byte_ch ();
    rscfp_out_if id_ch ();

    rfid_serial_card_frame_parser_top i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .id_ch   (id_ch)
    );

    logic [7:0]   held [rscfp_pkg::FRAME_BYTES];
    int           held_cnt   = 0;
    bit           frame_open = 1'b0;
    bit           locked     = 1'b0;
    card_result_t pending_ids [$];

    int errors     = 0;
    int bytes_sent = 0;
    int frame_ids  = 0;
    int raw_ids    = 0;
    int cycles     = 0;
    int stall_left = 0;
    bit gaps_on    = 1'b1;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int hex_value(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            return int'(ch) - 'h30;
        end
        if (ch >= 8'h41 && ch <= 8'h46)
        begin
            return int'(ch) - 'h41 + 10;
        end
        if (ch >= 8'h61 && ch <= 8'h66)
        begin
            return int'(ch) - 'h61 + 10;
        end
        return -1;
    endfunction

    function automatic int pair_value(input int pos);
        int hi;
        int lo;
        hi = hex_value(held[pos]);
        lo = hex_value(held[pos + 1]);
        if (hi < 0 || lo < 0)
        begin
            return -1;
        end
        return hi * 16 + lo;
    endfunction

    function automatic bit decode_frame(output logic [31:0] id);
        int part [5];
        int sum;
        int check;
        id  = '0;
        sum = 0;
        if (held[0] != rscfp_pkg::START_BYTE ||
            held[rscfp_pkg::FRAME_BYTES - 1] != rscfp_pkg::END_BYTE)
        begin
            return 1'b0;
        end
        for (int k = 0; k < 5; k++)
        begin
            part[k] = pair_value(1 + 2 * k);
            if (part[k] < 0)
            begin
                return 1'b0;
            end
            sum ^= part[k];
        end
        check = pair_value(11);
        if (check < 0 || check != sum)
        begin
            return 1'b0;
        end
        id = {part[1][7:0], part[2][7:0], part[3][7:0], part[4][7:0]};
        return id != '0;
    endfunction

    function automatic void drain_raw_groups();
        int pos;
        int rest;
        pos = 0;
        while (held_cnt - pos >= rscfp_pkg::RAW_BYTES)
        begin
            pending_ids.push_back('{{held[pos], held[pos + 1], held[pos + 2], held[pos + 3]},
                                    1'b1, 1'b0});
            pos += rscfp_pkg::RAW_BYTES;
        end
        rest = held_cnt - pos;
        for (int k = 0; k < rest; k++)
        begin
            held[k] = held[pos + k];
        end
        held_cnt = rest;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int           before_cnt;
        logic [31:0]  id;
        bit           resynced;
        card_result_t r;
        before_cnt = pending_ids.size();
        resynced   = 1'b0;
        if (frame_open)
        begin
            held[held_cnt] = b;
            held_cnt++;
            if (held_cnt == rscfp_pkg::FRAME_BYTES)
            begin
                if (decode_frame(id))
                begin
                    pending_ids.push_back('{id, 1'b0, 1'b0});
                    locked     = 1'b1;
                    frame_open = 1'b0;
                    held_cnt   = 0;
                end
                else
                begin
                    for (int j = 1; j < rscfp_pkg::FRAME_BYTES; j++)
                    begin
                        if (!resynced && held[j] == rscfp_pkg::START_BYTE)
                        begin
                            for (int k = 0; k < rscfp_pkg::FRAME_BYTES - j; k++)
                            begin
                                held[k] = held[j + k];
                            end
                            held_cnt = rscfp_pkg::FRAME_BYTES - j;
                            resynced = 1'b1;
                        end
                    end
                    if (!resynced)
                    begin
                        frame_open = 1'b0;
                        if (locked)
                        begin
                            held_cnt = 0;
                        end
                        else
                        begin
                            drain_raw_groups();
                        end
                    end
                end
            end
        end
        else if (b == rscfp_pkg::START_BYTE)
        begin
            held[0]    = b;
            held_cnt   = 1;
            frame_open = 1'b1;
        end
        else if (locked)
        begin
            held_cnt = 0;
        end
        else
        begin
            if (held_cnt >= rscfp_pkg::RAW_BYTES)
            begin
                held_cnt = 0;
            end
            held[held_cnt] = b;
            held_cnt++;
            drain_raw_groups();
        end
        if (pending_ids.size() > before_cnt)
        begin
            r      = pending_ids.pop_back();
            r.last = 1'b1;
            pending_ids.push_back(r);
        end
    endfunction

    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
        begin
            return 8'h30 + nib;
        end
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic void build_frame(input frame_kind_t kind, output frame_t f);
        logic [7:0] parts [5];
        logic [7:0] sum;
        int         pos;
        for (int k = 0; k < 5; k++)
        begin
            parts[k] = 8'($urandom_range(0, 255));
        end
        if (kind == FRAME_ZERO_ID)
        begin
            for (int k = 1; k < 5; k++)
            begin
                parts[k] = 8'h00;
            end
        end
        else if ({parts[1], parts[2], parts[3], parts[4]} == 32'h0)
        begin
            parts[4] = 8'h01;
        end
        sum = 8'h00;
        for (int k = 0; k < 5; k++)
        begin
            sum ^= parts[k];
        end
        if (kind == FRAME_BAD_SUM)
        begin
            sum ^= 8'($urandom_range(1, 255));
        end
        f[0] = rscfp_pkg::START_BYTE;
        for (int k = 0; k < 5; k++)
        begin
            f[1 + 2 * k] = nibble_ascii(parts[k][7:4], 1'($urandom_range(0, 1)));
            f[2 + 2 * k] = nibble_ascii(parts[k][3:0], 1'($urandom_range(0, 1)));
        end
        f[11] = nibble_ascii(sum[7:4], 1'($urandom_range(0, 1)));
        f[12] = nibble_ascii(sum[3:0], 1'($urandom_range(0, 1)));
        f[rscfp_pkg::FRAME_BYTES - 1] = rscfp_pkg::END_BYTE;
        case (kind)
            FRAME_BAD_END:
            begin
                do
                    f[rscfp_pkg::FRAME_BYTES - 1] = 8'($urandom_range(0, 255));
                while (f[rscfp_pkg::FRAME_BYTES - 1] == rscfp_pkg::END_BYTE);
            end
            FRAME_BAD_HEX:
            begin
                pos = $urandom_range(1, 12);
                do
                    f[pos] = 8'($urandom_range(0, 255));
                while (hex_value(f[pos]) >= 0);
            end
            FRAME_INNER_START:
            begin
                f[$urandom_range(1, rscfp_pkg::FRAME_BYTES - 1)] = rscfp_pkg::START_BYTE;
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        card_result_t want;
        if (rst_n && id_ch.valid && id_ch.ready)
        begin
            if (pending_ids.size() == 0)
            begin
                $error("unexpected card ID %08h (from_raw %0b, last %0b)",
                       id_ch.card_id, id_ch.from_raw, id_ch.last);
                errors++;
            end
            else
            begin
                want = pending_ids.pop_front();
                if (id_ch.card_id !== want.card_id)
                begin
                    $error("card_id: expected %08h, got %08h", want.card_id, id_ch.card_id);
                    errors++;
                end
                if (id_ch.from_raw !== want.from_raw)
                begin
                    $error("from_raw: expected %0b, got %0b", want.from_raw, id_ch.from_raw);
                    errors++;
                end
                if (id_ch.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, id_ch.last);
                    errors++;
                end
                if (want.from_raw)
                begin
                    raw_ids++;
                end
                else
                begin
                    frame_ids++;
                end
            end
        end
    end

    initial
    begin
        id_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 6);
            end
            id_ch.ready <= (stall_left == 0);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (byte_ch.ready !== 1'b1);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_kind_t kind);
        frame_t f;
        build_frame(kind, f);
        for (int k = 0; k < rscfp_pkg::FRAME_BYTES; k++)
        begin
            send_byte(f[k]);
        end
    endtask

    task automatic send_noise(input int count);
        for (int k = 0; k < count; k++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_ids.size() != 0);
    endtask

    task automatic test_raw_groups();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        repeat (rscfp_pkg::RAW_BYTES) send_byte(8'hFF);
    endtask

    task automatic test_bad_frame_to_raw();
        string digits;
        digits = "123456789A00";
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(rscfp_pkg::START_BYTE);
        for (int k = 0; k < digits.len(); k++)
        begin
            send_byte(digits[k]);
        end
        send_byte(rscfp_pkg::END_BYTE);
        send_byte(8'hC3);
        send_byte(8'h3C);
    endtask

    task automatic test_unlocked_random(input int count);
        int stop_at;
        int choice;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            gaps_on = ($urandom_range(0, 4) != 0);
            choice  = $urandom_range(0, 19);
            if (choice < 11)
            begin
                send_noise($urandom_range(1, 8));
            end
            else if (choice < 19)
            begin
                send_frame(frame_kind_t'($urandom_range(FRAME_BAD_SUM, FRAME_INNER_START)));
            end
            else
            begin
                wait_drained();
            end
        end
    endtask

    task automatic test_locked_random(input int count);
        int stop_at;
        int choice;
        stop_at = bytes_sent + count;
        send_frame(FRAME_GOOD);
        while (bytes_sent < stop_at)
        begin
            gaps_on = ($urandom_range(0, 4) != 0);
            choice  = $urandom_range(0, 19);
            if (choice < 13)
            begin
                send_frame(FRAME_GOOD);
            end
            else if (choice < 17)
            begin
                send_frame(frame_kind_t'($urandom_range(FRAME_BAD_SUM, FRAME_INNER_START)));
            end
            else if (choice < 19)
            begin
                send_noise($urandom_range(1, 4));
            end
            else
            begin
                wait_drained();
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        gaps_on = 1'b0;
        while (bytes_sent < stop_at)
        begin
            send_frame(FRAME_GOOD);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_raw_groups();
        test_bad_frame_to_raw();
        wait_drained();
        test_unlocked_random(130);
        wait_drained();
        test_locked_random(220);
        test_back_to_back(56);

        byte_ch.valid <= 1'b0;
        while (pending_ids.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d reader bytes: raw groups, bad frames with resync, then locked framing.",
                 bytes_sent);
        $display("Checked %0d frame IDs and %0d raw IDs, %0d mismatches.",
                 frame_ids, raw_ids, errors);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
